FILE: rtl/gdo_pkg.sv
// ----------------------------------------------------------------------------
// gdo_pkg
// Shared types, constants and the month length table for the Gregorian
// date offset block.
// ----------------------------------------------------------------------------
package gdo_pkg;

  // Default width of the signed day offset.
  localparam int GDO_OFFSET_BITS_DEF = 16;

  // Field widths.
  localparam int DAY_W      = 5;
  localparam int MON_W      = 4;
  localparam int YEAR_IN_W  = 14;
  localparam int YEAR_OUT_W = 15;
  // Internal year width covers 9999 plus the largest offset span in years.
  localparam int YEAR_W     = 17;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;

  // Year mod 400 is carried as a residue of this width.
  localparam int R400_W = 9;

  // Reciprocal used to divide the base year by 400: q = (y * 5243) >> 21.
  localparam int RECIP_W     = 13;
  localparam int RECIP       = 5243;
  localparam int RECIP_SHIFT = 21;
  localparam int QPROD_W     = YEAR_IN_W + RECIP_W;
  localparam int QUOT_W      = QPROD_W - RECIP_SHIFT;

  localparam int YEAR_MAX_IN  = 9999;
  localparam int YEAR_OUT_MIN = -16384;
  localparam int YEAR_OUT_MAX = 16383;

  localparam int BASE_DAY_RST   = 1;
  localparam int BASE_MONTH_RST = 1;
  localparam int BASE_YEAR_RST  = 2000;

  localparam int MONTHS = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_DAY   = 2'd0,
    CFG_BASE_MONTH = 2'd1,
    CFG_BASE_YEAR  = 2'd2
  } gdo_cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MODR,
    ST_CLAMP,
    ST_STEP
  } gdo_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // capture offset, base day and clamped base year and month
    logic mod_en;    // compute year mod 400
    logic clamp_en;  // clamp the base day to its month
    logic step_en;   // move one day
    logic load_out;  // copy the finished date into the output register
  } gdo_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic count_zero;
  } gdo_status_t;

  // Number of days in a month, given whether the year is a leap year.
  function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] mon,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (mon)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

FILE: rtl/gdo_ifs.sv
// ----------------------------------------------------------------------------
// gdo_ifs
// Valid/ready channel interfaces for the offset input, the date result and
// the configuration writes.
// ----------------------------------------------------------------------------
interface gdo_in_if #(parameter int W = 16);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] offset_days;

  modport source (output valid, output offset_days, input ready);
  modport sink   (input valid, input offset_days, output ready);
endinterface

interface gdo_out_if;
  logic               valid;
  logic               ready;
  logic [4:0]         result_day;
  logic [3:0]         result_month;
  logic signed [14:0] result_year;

  modport source (output valid, output result_day, output result_month,
                  output result_year, input ready);
  modport sink   (input valid, input result_day, input result_month,
                  input result_year, output ready);
endinterface

interface gdo_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [13:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/gdo_ctrl.sv
// ----------------------------------------------------------------------------
// gdo_ctrl
// Sequencer: starts an item, runs the residue and clamp steps, then steps
// one day per cycle and hands the date to the output register.
// ----------------------------------------------------------------------------
module gdo_ctrl import gdo_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  gdo_status_t status,
  output gdo_cmd_t    cmd
);

  gdo_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign in_ready  = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_MODR;
        end
      end
      ST_MODR: begin
        cmd.mod_en = 1'b1;
        state_nxt  = ST_CLAMP;
      end
      ST_CLAMP: begin
        cmd.clamp_en = 1'b1;
        state_nxt    = ST_STEP;
      end
      ST_STEP: begin
        if (!status.count_zero) begin
          cmd.step_en = 1'b1;
        end else if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/gdo_datapath.sv
// ----------------------------------------------------------------------------
// gdo_datapath
// Base date registers, the running date with its year residue mod 400, the
// day counter and the output register.
// ----------------------------------------------------------------------------
module gdo_datapath import gdo_pkg::*; #(
  parameter int OFFSET_BITS = GDO_OFFSET_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  gdo_cmd_t                      cmd,
  output gdo_status_t                   status,
  input  logic signed [OFFSET_BITS-1:0] offset_days,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  output logic [DAY_W-1:0]              result_day,
  output logic [MON_W-1:0]              result_month,
  output logic signed [YEAR_OUT_W-1:0]  result_year
);

  localparam logic signed [YEAR_W-1:0] YMIN = YEAR_W'(YEAR_OUT_MIN);
  localparam logic signed [YEAR_W-1:0] YMAX = YEAR_W'(YEAR_OUT_MAX);
  localparam logic [R400_W-1:0]        R400_LAST = R400_W'(399);

  // Configuration registers.
  logic [DAY_W-1:0]     base_day_r;
  logic [MON_W-1:0]     base_month_r;
  logic [YEAR_IN_W-1:0] base_year_r;

  // Working registers.
  logic signed [YEAR_W-1:0]     year_r;
  logic [MON_W-1:0]             mon_r;
  logic [DAY_W-1:0]             day_r;
  logic [R400_W-1:0]            r400_r;
  logic [QPROD_W-1:0]           qprod_r;
  logic [OFFSET_BITS-1:0]       cnt_r;
  logic                         neg_r;
  logic [DAY_W-1:0]             res_day_r;
  logic [MON_W-1:0]             res_mon_r;
  logic [YEAR_OUT_W-1:0]        res_year_r;

  logic [YEAR_IN_W-1:0] year_clamp;
  logic [MON_W-1:0]     mon_clamp;
  logic [QUOT_W-1:0]    quot;
  logic [YEAR_IN_W-1:0] quot_x400;
  logic [YEAR_IN_W-1:0] rem_full;
  logic                 leap;
  logic [DAY_W-1:0]     ml_cur;
  logic [DAY_W-1:0]     ml_prev;
  logic signed [YEAR_W-1:0] year_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_day_r   <= DAY_W'(BASE_DAY_RST);
      base_month_r <= MON_W'(BASE_MONTH_RST);
      base_year_r  <= YEAR_IN_W'(BASE_YEAR_RST);
    end else if (cfg_we) begin
      if (cfg_index == CFG_BASE_DAY)   base_day_r   <= cfg_data[DAY_W-1:0];
      if (cfg_index == CFG_BASE_MONTH) base_month_r <= cfg_data[MON_W-1:0];
      if (cfg_index == CFG_BASE_YEAR)  base_year_r  <= cfg_data[YEAR_IN_W-1:0];
    end
  end

  always_comb begin
    year_clamp = (base_year_r > YEAR_IN_W'(YEAR_MAX_IN)) ? YEAR_IN_W'(YEAR_MAX_IN)
                                                          : base_year_r;
    if (base_month_r == '0)                   mon_clamp = MON_W'(1);
    else if (base_month_r > MON_W'(MONTHS))   mon_clamp = MON_W'(MONTHS);
    else                                      mon_clamp = base_month_r;
  end

  // Year mod 400 from the registered reciprocal product.
  assign quot      = qprod_r[QPROD_W-1:RECIP_SHIFT];
  assign quot_x400 = (YEAR_IN_W'(quot) << 8) + (YEAR_IN_W'(quot) << 7)
                   + (YEAR_IN_W'(quot) << 4);
  assign rem_full  = year_r[YEAR_IN_W-1:0] - quot_x400;

  // Divisible by 4 but not by 100, or divisible by 400.
  assign leap = (r400_r[1:0] == 2'b00) && (r400_r != R400_W'(100))
             && (r400_r != R400_W'(200)) && (r400_r != R400_W'(300));
  assign ml_cur  = month_len(mon_r, leap);
  assign ml_prev = month_len(mon_r - MON_W'(1), leap);

  always_comb begin
    if (year_r < YMIN)      year_sat = YMIN;
    else if (year_r > YMAX) year_sat = YMAX;
    else                    year_sat = year_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      year_r  <= YEAR_W'(year_clamp);
      mon_r   <= mon_clamp;
      day_r   <= base_day_r;
      qprod_r <= QPROD_W'(year_clamp) * QPROD_W'(RECIP);
      neg_r   <= offset_days[OFFSET_BITS-1];
      cnt_r   <= offset_days[OFFSET_BITS-1] ? OFFSET_BITS'(-offset_days)
                                            : OFFSET_BITS'(offset_days);
    end
    if (cmd.mod_en) begin
      r400_r <= rem_full[R400_W-1:0];
    end
    if (cmd.clamp_en) begin
      if (day_r == '0)         day_r <= DAY_W'(1);
      else if (day_r > ml_cur) day_r <= ml_cur;
    end
    if (cmd.step_en) begin
      cnt_r <= cnt_r - OFFSET_BITS'(1);
      if (!neg_r) begin
        if (day_r == ml_cur) begin
          day_r <= DAY_W'(1);
          if (mon_r == MON_W'(MONTHS)) begin
            mon_r  <= MON_W'(1);
            year_r <= year_r + YEAR_W'(1);
            r400_r <= (r400_r == R400_LAST) ? '0 : r400_r + R400_W'(1);
          end else begin
            mon_r <= mon_r + MON_W'(1);
          end
        end else begin
          day_r <= day_r + DAY_W'(1);
        end
      end else begin
        if (day_r == DAY_W'(1)) begin
          if (mon_r == MON_W'(1)) begin
            mon_r  <= MON_W'(MONTHS);
            day_r  <= DAY_W'(31);
            year_r <= year_r - YEAR_W'(1);
            r400_r <= (r400_r == '0) ? R400_LAST : r400_r - R400_W'(1);
          end else begin
            mon_r <= mon_r - MON_W'(1);
            day_r <= ml_prev;
          end
        end else begin
          day_r <= day_r - DAY_W'(1);
        end
      end
    end
    if (cmd.load_out) begin
      res_day_r  <= day_r;
      res_mon_r  <= mon_r;
      res_year_r <= year_sat[YEAR_OUT_W-1:0];
    end
  end

  assign status.count_zero = (cnt_r == '0);
  assign result_day   = res_day_r;
  assign result_month = res_mon_r;
  assign result_year  = res_year_r;

endmodule

FILE: rtl/gregorian_date_offset.sv
// ----------------------------------------------------------------------------
// gregorian_date_offset
// Adds a signed day offset to a configured Gregorian base date.
// ----------------------------------------------------------------------------
// Each input beat is followed by the residue and clamp steps; the day stepper
// then moves the running date by one day per cycle until the day counter is
// empty. No new offset is taken until that date is in the output register.
// The next input beat is taken while a finished result waits to be taken.
// Reset (rst_n, synchronous): base date returns to 2000-01-01, control idles.
// ----------------------------------------------------------------------------
module gregorian_date_offset import gdo_pkg::*; #(
  parameter int OFFSET_BITS = GDO_OFFSET_BITS_DEF
) (
  input logic          clk,
  input logic          rst_n,
  gdo_in_if.sink       in_if,
  gdo_out_if.source    out_if,
  gdo_cfg_if.sink      cfg_if
);

  // The controller and datapath talk only through these two bundles.
  gdo_cmd_t    cmd;
  gdo_status_t status;

  // Configuration writes land in the datapath on any cycle; the host must only
  // write while the block is idle (not enforced here), so no hold-off is used.
  assign cfg_if.ready = 1'b1;

  // The controller sequences each item: an accept beat loads the base date,
  // with year and month clamped, and the reciprocal product; the ST_MODR state
  // derives the year residue mod 400 (which drives the leap-year test from
  // then on), the ST_CLAMP state clamps the base day to its month, and then
  // the datapath steps one day per cycle until the day counter is empty.
  gdo_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath keeps the running date, its year residue, the remaining
  // day count and the direction, plus the output register that holds a
  // finished result until the output beat is taken.
  gdo_datapath #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .offset_days  (in_if.offset_days),
    .cfg_we       (cfg_if.valid),
    .cfg_index    (cfg_if.index),
    .cfg_data     (cfg_if.data),
    .result_day   (out_if.result_day),
    .result_month (out_if.result_month),
    .result_year  (out_if.result_year)
  );

endmodule

FILE: tb/gregorian_date_offset_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gregorian_date_offset_test
// Self-checking bench for the Gregorian date offset block. A directed table
// covers reset, the offset extremes, century leap rules and the clamping of
// out-of-range base dates. Random phases follow, each under new base dates,
// with idle gaps on the offset side, stalls on the result side and one long
// hold-off of the result channel. Every result beat is compared field by
// field against an in-bench model of proleptic Gregorian date arithmetic.
// ----------------------------------------------------------------------------
module gregorian_date_offset_test;
  import gdo_pkg::*;

  // The run is bounded far above the slowest legal run: roughly 105 offsets
  // of full magnitude, each also waiting out a long result stall.
  localparam int CYCLE_LIMIT = 20_000_000;

  // Index three decodes to no register, so a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  localparam int PHASES          = 4;
  localparam int ITEMS_PER_PHASE = 20;
  // The base date is rewritten this often inside a random phase.
  localparam int ITEMS_PER_BASE  = 10;
  localparam int HOLD_CYCLES     = 3000;
  localparam int DIRECTED_ROWS   = 25;

  typedef struct packed {
    logic [DAY_W-1:0]             day;
    logic [MON_W-1:0]             month;
    logic signed [YEAR_OUT_W-1:0] year;
  } date_t;

  // One directed beat: the raw register words for the base date, whether to
  // also poke the unused register index, the offset, and, where it is obvious,
  // the result typed in by hand.
  typedef struct packed {
    logic [CFG_DATA_W-1:0] day_word;
    logic [CFG_DATA_W-1:0] month_word;
    logic [CFG_DATA_W-1:0] year_word;
    logic                  poke_unused;
    logic signed [15:0]    offset;
    logic                  typed;
    date_t                 want;
  } directed_row_t;

  localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
    // Straight out of reset the base is the first of January 2000.
    '{14'd1,  14'd1,  14'd2000,  1'b0, 16'sd0,      1'b1, '{5'd1,  4'd1,  15'sd2000}},
    '{14'd1,  14'd1,  14'd2000,  1'b0, 16'sd59,     1'b0, '0},
    '{14'd1,  14'd1,  14'd2000,  1'b0, -16'sd1,     1'b0, '0},
    '{14'd1,  14'd1,  14'd2000,  1'b0, 16'sd32767,  1'b0, '0},
    '{14'd1,  14'd1,  14'd2000,  1'b0, -16'sd32768, 1'b0, '0},
    // A write to the unused index leaves the base date untouched.
    '{14'd1,  14'd1,  14'd2000,  1'b1, 16'sd0,      1'b1, '{5'd1,  4'd1,  15'sd2000}},
    // Leap rules: 1900 and 2100 are common, 2004 and 2000 are leap.
    '{14'd28, 14'd2,  14'd1900,  1'b0, 16'sd1,      1'b0, '0},
    '{14'd28, 14'd2,  14'd2004,  1'b0, 16'sd1,      1'b0, '0},
    '{14'd28, 14'd2,  14'd2100,  1'b0, 16'sd1,      1'b0, '0},
    '{14'd29, 14'd2,  14'd2000,  1'b0, 16'sd365,    1'b0, '0},
    // Far past the last legal base year, and across year zero into the
    // negative years.
    '{14'd31, 14'd12, 14'd9999,  1'b0, 16'sd32767,  1'b0, '0},
    '{14'd31, 14'd12, 14'd9999,  1'b0, 16'sd1,      1'b0, '0},
    '{14'd1,  14'd1,  14'd0,     1'b0, -16'sd32768, 1'b0, '0},
    '{14'd1,  14'd1,  14'd0,     1'b0, -16'sd1,     1'b0, '0},
    // Out-of-range base fields are clamped before any stepping.
    '{14'd0,  14'd5,  14'd2023,  1'b0, 16'sd0,      1'b1, '{5'd1,  4'd5,  15'sd2023}},
    '{14'd15, 14'd0,  14'd2023,  1'b0, 16'sd0,      1'b1, '{5'd15, 4'd1,  15'sd2023}},
    '{14'd10, 14'd13, 14'd2023,  1'b0, 16'sd0,      1'b1, '{5'd10, 4'd12, 15'sd2023}},
    '{14'd31, 14'd15, 14'd2023,  1'b0, 16'sd0,      1'b1, '{5'd31, 4'd12, 15'sd2023}},
    '{14'd31, 14'd4,  14'd2023,  1'b0, 16'sd0,      1'b1, '{5'd30, 4'd4,  15'sd2023}},
    '{14'd31, 14'd2,  14'd2023,  1'b0, 16'sd0,      1'b1, '{5'd28, 4'd2,  15'sd2023}},
    '{14'd31, 14'd2,  14'd2024,  1'b0, 16'sd0,      1'b1, '{5'd29, 4'd2,  15'sd2024}},
    '{14'd1,  14'd1,  14'd16383, 1'b0, 16'sd0,      1'b1, '{5'd1,  4'd1,  15'sd9999}},
    '{14'd12, 14'd3,  14'd10000, 1'b0, 16'sd0,      1'b1, '{5'd12, 4'd3,  15'sd9999}},
    // Register words wider than the field keep only their low bits.
    '{14'h3FE5, 14'h3FF7, 14'd2023, 1'b0, 16'sd0,   1'b1, '{5'd5,  4'd7,  15'sd2023}},
    '{14'd15, 14'd6,  14'd1999,  1'b0, -16'sd100,   1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst_n;

  gdo_in_if #(.W(GDO_OFFSET_BITS_DEF)) in_ch ();
  gdo_out_if                           out_ch ();
  gdo_cfg_if                           cfg_ch ();

  gregorian_date_offset #(.OFFSET_BITS(GDO_OFFSET_BITS_DEF)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // Base date as the block should hold it after every register beat.
  logic [DAY_W-1:0]     base_day_q;
  logic [MON_W-1:0]     base_month_q;
  logic [YEAR_IN_W-1:0] base_year_q;

  // Raw words last written, so the directed walk only reconfigures on change.
  logic [CFG_DATA_W-1:0] last_day_word;
  logic [CFG_DATA_W-1:0] last_month_word;
  logic [CFG_DATA_W-1:0] last_year_word;

  date_t pending_dates [$];
  int    mismatch_count;
  int    cycle_count;

  // Idle and stall rates are changed by nonblocking writes at a clock edge so
  // that the receiver process never races the main sequence on them.
  int   send_idle_pct;
  int   recv_stall_pct;
  logic hold_off;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Date arithmetic. Dates are turned into a day count from 1970-01-01 using
  // 400-year eras, shifted, and turned back. Division truncates toward zero,
  // so negative values are biased by one era less one year or day before dividing.
  // --------------------------------------------------------------------------
  function automatic bit is_leap(longint yr);
    return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
  endfunction

  function automatic longint days_in_month(longint mo, longint yr);
    case (mo)
      2:            return is_leap(yr) ? 29 : 28;
      4, 6, 9, 11:  return 30;
      default:      return 31;
    endcase
  endfunction

  function automatic longint serial_from_date(longint yr, longint mo, longint dy);
    longint era, yoe, doy, doe;
    // The year is taken to start in March so the leap day falls last.
    if (mo <= 2) yr = yr - 1;
    era = (yr >= 0 ? yr : yr - 399) / 400;
    yoe = yr - era * 400;
    doy = (153 * (mo > 2 ? mo - 3 : mo + 9) + 2) / 5 + dy - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * 146097 + doe - 719468;
  endfunction

  function automatic void date_from_serial(longint z, output longint yr,
                                           output longint mo, output longint dy);
    longint era, doe, yoe, doy, mp;
    z   = z + 719468;
    era = (z >= 0 ? z : z - 146096) / 146097;
    doe = z - era * 146097;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp  = (5 * doy + 2) / 153;
    dy  = doy - (153 * mp + 2) / 5 + 1;
    mo  = mp < 10 ? mp + 3 : mp - 9;
    yr  = yoe + era * 400 + (mo <= 2 ? 1 : 0);
  endfunction

  // The date that lies the given number of days from the current base date.
  function automatic date_t shift_base_date(logic signed [15:0] offset);
    longint yr, mo, dy, len;
    date_t  res;
    yr = (base_year_q > YEAR_MAX_IN) ? YEAR_MAX_IN : base_year_q;
    mo = base_month_q;
    if (mo < 1) mo = 1;
    if (mo > MONTHS) mo = MONTHS;
    len = days_in_month(mo, yr);
    dy  = base_day_q;
    if (dy < 1) dy = 1;
    if (dy > len) dy = len;
    date_from_serial(serial_from_date(yr, mo, dy) + longint'(offset), yr, mo, dy);
    if (yr < YEAR_OUT_MIN) yr = YEAR_OUT_MIN;
    if (yr > YEAR_OUT_MAX) yr = YEAR_OUT_MAX;
    res.day   = dy[DAY_W-1:0];
    res.month = mo[MON_W-1:0];
    res.year  = yr[YEAR_OUT_W-1:0];
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Register writes. The caller lowers valid after its last beat, so a burst
  // of writes keeps valid high without a drop inside one time step.
  // --------------------------------------------------------------------------
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] word);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= word;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_BASE_DAY:   base_day_q   = word[DAY_W-1:0];
      CFG_BASE_MONTH: base_month_q = word[MON_W-1:0];
      CFG_BASE_YEAR:  base_year_q  = word[YEAR_IN_W-1:0];
      default: ;
    endcase
  endtask

  // Waits until every result has come back, then rewrites the base date.
  // Every offset yields a result, so an empty queue means the block is idle.
  task automatic reconfigure(logic [CFG_DATA_W-1:0] day_word,
                             logic [CFG_DATA_W-1:0] month_word,
                             logic [CFG_DATA_W-1:0] year_word, logic poke_unused);
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    write_register(CFG_BASE_DAY, day_word);
    write_register(CFG_BASE_MONTH, month_word);
    write_register(CFG_BASE_YEAR, year_word);
    if (poke_unused) write_register(CFG_UNUSED_IDX, {CFG_DATA_W{1'b1}});
    cfg_ch.valid    <= 1'b0;
    last_day_word   = day_word;
    last_month_word = month_word;
    last_year_word  = year_word;
  endtask

  // Offers one offset beat, possibly after some idle cycles, and records the
  // expected date once the beat is taken. Valid stays high afterward; the
  // next call or the caller decides when it drops.
  task automatic offer_offset(logic signed [15:0] offset, date_t want);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.offset_days <= offset;
    do @(posedge clk); while (!in_ch.ready);
    pending_dates.push_back(want);
  endtask

  // Mostly short offsets keep the day stepper fast; about one in twelve spans
  // the whole 16-bit range.
  function automatic logic signed [15:0] pick_offset();
    int unsigned kind, mag;
    kind = $urandom_range(0, 11);
    if (kind == 0) return 16'($urandom);
    if (kind <= 4)      mag = $urandom_range(0, 40);
    else if (kind <= 8) mag = $urandom_range(0, 400);
    else                mag = $urandom_range(0, 3000);
    return $urandom_range(0, 1) ? -16'(mag) : 16'(mag);
  endfunction

  task automatic hold_receiver(int cycles);
    hold_off <= 1'b1;
    repeat (cycles) @(posedge clk);
    hold_off <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Result side: check each taken beat against the oldest expectation, then
  // pick ready for the next cycle.
  // --------------------------------------------------------------------------
  task automatic check_result();
    date_t want;
    if (pending_dates.size() == 0) begin
      $error("result beat with no offset outstanding: %0d-%0d-%0d",
             $signed(out_ch.result_year), out_ch.result_month, out_ch.result_day);
      mismatch_count++;
      return;
    end
    want = pending_dates.pop_front();
    if (out_ch.result_day !== want.day) begin
      $error("result_day: expected %0d, got %0d", want.day, out_ch.result_day);
      mismatch_count++;
    end
    if (out_ch.result_month !== want.month) begin
      $error("result_month: expected %0d, got %0d", want.month, out_ch.result_month);
      mismatch_count++;
    end
    if (out_ch.result_year !== want.year) begin
      $error("result_year: expected %0d, got %0d", want.year,
             $signed(out_ch.result_year));
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) check_result();
    if (hold_off) begin
      out_ch.ready <= 1'b0;
    end else if (recv_stall_pct != 0 && $urandom_range(0, 99) < recv_stall_pct) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence: reset, the directed table, then the random phases.
  // --------------------------------------------------------------------------
  initial begin
    date_t                 want;
    logic signed [15:0]    offset;
    logic [CFG_DATA_W-1:0] year_word;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.offset_days = '0;
    out_ch.ready      = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = '0;
    cfg_ch.data       = '0;
    hold_off          = 1'b0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    mismatch_count    = 0;
    cycle_count       = 0;
    base_day_q        = DAY_W'(BASE_DAY_RST);
    base_month_q      = MON_W'(BASE_MONTH_RST);
    base_year_q       = YEAR_IN_W'(BASE_YEAR_RST);
    last_day_word     = CFG_DATA_W'(BASE_DAY_RST);
    last_month_word   = CFG_DATA_W'(BASE_MONTH_RST);
    last_year_word    = CFG_DATA_W'(BASE_YEAR_RST);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table. The first rows run on the reset base with no writes at
    // all, which checks the reset values of the three registers.
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      if (DIRECTED[r].poke_unused || DIRECTED[r].day_word != last_day_word ||
          DIRECTED[r].month_word != last_month_word ||
          DIRECTED[r].year_word != last_year_word) begin
        in_ch.valid <= 1'b0;
        reconfigure(DIRECTED[r].day_word, DIRECTED[r].month_word,
                    DIRECTED[r].year_word, DIRECTED[r].poke_unused);
      end
      want = DIRECTED[r].typed ? DIRECTED[r].want : shift_base_date(DIRECTED[r].offset);
      offer_offset(DIRECTED[r].offset, want);
    end
    in_ch.valid <= 1'b0;

    // Random phases: no idling, idle sender, stalling receiver, then both.
    // The first phase also holds the result side off for a long stretch so
    // the block fills and has to back-pressure the offset side.
    for (int p = 0; p < PHASES; p++) begin
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (i % ITEMS_PER_BASE == 0) begin
          // Full random register words exercise the ignored upper bits; the
          // year mostly stays within the legal range so clamping stays rare.
          year_word = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom)
                                                  : CFG_DATA_W'($urandom_range(0, 9999));
          reconfigure(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), year_word, 1'b0);
          if (i == 0) begin
            send_idle_pct  <= (p == 1) ? 49 : (p == 3) ? 12 : 0;
            recv_stall_pct <= (p == 2) ? 49 : (p == 3) ? 12 : 0;
            if (p == 0) begin
              fork
                hold_receiver(HOLD_CYCLES);
              join_none
            end
          end
        end
        offset = pick_offset();
        offer_offset(offset, shift_base_date(offset));
        if (i % ITEMS_PER_BASE == ITEMS_PER_BASE - 1 || i == ITEMS_PER_PHASE - 1) begin
          in_ch.valid <= 1'b0;
        end
      end
    end

    while (pending_dates.size() != 0) @(posedge clk);
    // The wait below catches any stray result beat.
    repeat (64) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/gdo_pkg.sv
rtl/gdo_ifs.sv
rtl/gdo_ctrl.sv
rtl/gdo_datapath.sv
rtl/gregorian_date_offset.sv
tb/gregorian_date_offset_test.sv
